// ===== rtl/core/kpdc_pkg.sv =====
// Shared types and constants for the key press duration classifier.
`timescale 1ns / 1ps

package kpdc_pkg;

    // Per-key action codes, as seen in each 3-bit field of the key actions.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_HOLD  = 3'd2,
        ACT_SHORT = 3'd3,
        ACT_LONG  = 3'd4
    } t_action;

    localparam int ACT_W          = 3;
    localparam int KEY_IN_W       = 4;
    localparam int KEY_ACTIONS_W  = 12;
    localparam int KEYS_SHOWN_MAX = KEY_ACTIONS_W / ACT_W;
    localparam int THRESH_W       = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;

    localparam int NUM_KEYS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 16;

endpackage : kpdc_pkg

// ===== rtl/core/key_press_duration_classifier.sv =====
// Top level of the key press duration classifier: per-key state machines and counters.
`timescale 1ns / 1ps

// An accepted beat is written into the output register, where its result shows from
// the cycle after the beat is taken.
// Throughput: one beat per cycle while results are taken. The per-key state and counter
// update is a single combinational step from the state registers to the result register.
// Reset (synchronous, active low) clears every key to "not pressed", zeroes the hold
// counters, empties the result register and loads the long press threshold with 50.
module key_press_duration_classifier #(
    parameter int NUM_KEYS    = kpdc_pkg::NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = kpdc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: long press threshold
    input  logic                                i_cfg_we,
    input  logic [kpdc_pkg::THRESH_W-1:0]       i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_scan_ok,
    input  logic [kpdc_pkg::KEY_IN_W-1:0]       i_key_pressed,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_status,
    output logic [kpdc_pkg::KEY_ACTIONS_W-1:0]  o_key_actions
);
    import kpdc_pkg::*;

    // Width used for the release comparison: wide enough for counter and threshold.
    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
    // Keys that have a field in the key actions output.
    localparam int KEYS_SHOWN = (NUM_KEYS < KEYS_SHOWN_MAX) ? NUM_KEYS : KEYS_SHOWN_MAX;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    t_action                r_state [NUM_KEYS];
    t_action                n_state [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] r_count [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] n_count [NUM_KEYS];

    logic [THRESH_W-1:0]      r_threshold;
    logic                     r_out_valid;
    logic                     r_status;
    logic [KEY_ACTIONS_W-1:0] r_key_actions;
    logic [KEY_ACTIONS_W-1:0] n_key_actions;

    // Pressed bits padded with zeros, so that keys beyond the input field read as released.
    logic [NUM_KEYS+KEY_IN_W-1:0] w_pressed_ext;
    logic                         w_in_beat;

    // The result register frees itself in the same cycle it is read, so a new beat is
    // taken whenever the register is empty or its contents are being taken.
    assign o_in_ready    = !r_out_valid || i_out_ready;
    assign w_in_beat     = i_in_valid && o_in_ready;
    assign w_pressed_ext = {{NUM_KEYS{1'b0}}, i_key_pressed};

    // Next state and counter for every key. A failed scan leaves everything as it is.
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_state[k] = r_state[k];
            n_count[k] = r_count[k];
            if (i_scan_ok) begin
                case (r_state[k])
                    ACT_START, ACT_HOLD: begin
                        if (w_pressed_ext[k]) begin
                            // Hold counter saturates at its top value.
                            if (r_count[k] != COUNT_MAX) begin
                                n_count[k] = r_count[k] + 1'b1;
                            end
                            n_state[k] = ACT_HOLD;
                        end else if (CMP_W'(r_count[k]) >= CMP_W'(r_threshold)) begin
                            n_state[k] = ACT_LONG;
                        end else begin
                            n_state[k] = ACT_SHORT;
                        end
                    end
                    default: begin
                        // Not pressed, or either end of a press: a press starts afresh.
                        if (w_pressed_ext[k]) begin
                            n_count[k] = '0;
                            n_state[k] = ACT_START;
                        end else begin
                            n_state[k] = ACT_NONE;
                        end
                    end
                endcase
            end
        end
    end

    // Output packing: three bits per key, keys without a field are dropped.
    always_comb begin
        n_key_actions = '0;
        for (int k = 0; k < KEYS_SHOWN; k++) begin
            n_key_actions[ACT_W*k +: ACT_W] = n_state[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_state[k] <= ACT_NONE;
                r_count[k] <= '0;
            end
        end else if (w_in_beat) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_state[k] <= n_state[k];
                r_count[k] <= n_count[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_status      <= i_scan_ok;
            r_key_actions <= n_key_actions;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_key_actions = r_key_actions;

endmodule : key_press_duration_classifier

// ===== rtl/core/kpdc_checker.sv =====
// Port-level checker for the key press duration classifier, with its bind statement.
`timescale 1ns / 1ps

module kpdc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_scan_ok,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_status,
    input logic [kpdc_pkg::KEY_ACTIONS_W-1:0]  o_key_actions
);
    import kpdc_pkg::*;

    // After reset the result register is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before being taken");

    // Every accepted beat gives a result in the next cycle, with the scan flag echoed.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid && (o_status == $past(i_scan_ok)))
        else $error("result missing or status wrong after accepted beat");

    // The input side never stalls while the result register is empty.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Only the five defined actions appear in any key field.
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !(o_key_actions[2]  && (o_key_actions[1]  || o_key_actions[0]))  &&
            !(o_key_actions[5]  && (o_key_actions[4]  || o_key_actions[3]))  &&
            !(o_key_actions[8]  && (o_key_actions[7]  || o_key_actions[6]))  &&
            !(o_key_actions[11] && (o_key_actions[10] || o_key_actions[9])))
        else $error("undefined key action code");

endmodule : kpdc_checker

bind key_press_duration_classifier kpdc_checker u_kpdc_checker (.*);
